// File: hdl/dzfc_pkg.sv
package dzfc_pkg;

    // Block sizing
    localparam int NUM_CLASSES = 64;
    localparam int MAX_COUNT   = 256;
    localparam int COORD_BITS  = 12;

    // Fixed register subfield widths
    localparam int LINE_BITS      = 12;
    localparam int AREA_REG_BITS  = 24;
    localparam int CLASS_REG_BITS = 6;
    localparam int MASK_BITS      = 64;
    localparam int SCORE_BITS     = 16;

    // Derived widths
    localparam int CLASS_BITS = $clog2(NUM_CLASSES);
    localparam int CNT_BITS   = $clog2(MAX_COUNT + 1);
    localparam int BOT_BITS   = COORD_BITS + 1;
    localparam int CMP_BITS   = (BOT_BITS > LINE_BITS) ? BOT_BITS : LINE_BITS;
    localparam int DIFF_BITS  = CMP_BITS + 1;
    localparam int LDIFF_BITS = LINE_BITS + 1;
    localparam int PROD_BITS  = LDIFF_BITS + DIFF_BITS;
    localparam int HCMP_BITS  = (COORD_BITS > LINE_BITS) ? COORD_BITS : LINE_BITS;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int ACMP_BITS  = (AREA_BITS > AREA_REG_BITS) ? AREA_BITS : AREA_REG_BITS;

    // Register file
    localparam int NUM_REGS     = 8;
    localparam int DATA_BITS    = 64;
    localparam int ADDR_LSB     = 3;
    localparam int REG_IDX_BITS = $clog2(NUM_REGS);
    localparam int ADDR_BITS    = REG_IDX_BITS + ADDR_LSB;

    localparam logic [SCORE_BITS-1:0] SCORE_THRESHOLD_RESET = 16'd19661;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SCORE_THRESHOLD     = 3'd0,
        REG_IGNORE_ABOVE_ROW    = 3'd1,
        REG_IGNORE_LINE         = 3'd2,
        REG_PERSON_MIN_AREA     = 3'd3,
        REG_PERSON_HEIGHT_RULES = 3'd4,
        REG_VEHICLE_AREA_LIMITS = 3'd5,
        REG_PERSON_CLASS        = 3'd6,
        REG_VEHICLE_CLASS_MASK  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        VERDICT_REJECT  = 2'd0,
        VERDICT_PERSON  = 2'd1,
        VERDICT_VEHICLE = 2'd2
    } t_verdict;

    // Captured input request
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [SCORE_BITS-1:0] score;
        logic                  box_last;
        logic                  frame_last;
    } t_stage_a;

    // Box geometry and winning class, ready for the tests
    typedef struct packed {
        logic [SCORE_BITS-1:0]       best_score;
        logic [CLASS_BITS-1:0]       best_class;
        logic [COORD_BITS-1:0]       x;
        logic [COORD_BITS-1:0]       h;
        logic [BOT_BITS-1:0]         bottom;
        logic [AREA_BITS-1:0]        area;
        logic signed [PROD_BITS-1:0] p_common;
        logic signed [PROD_BITS-1:0] p_left;
        logic signed [PROD_BITS-1:0] p_right;
        logic                        frame_last;
    } t_stage_b;

endpackage

// File: hdl/detection_zone_filter_counter.sv
// A box's last score request goes from the input register via the stage B register to
// the output register; a score without box_last produces no result. Throughput: one
// score request per cycle while stage B can take last scores, set by the argmax loop
// on the best-score register; line test products are registered before the compare.
// Reset (i_rst_n low, synchronous): pipeline empty, argmax and frame counts cleared,
// configuration back to defaults (score threshold 19661, all else zero).
module detection_zone_filter_counter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input scores
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [dzfc_pkg::COORD_BITS-1:0]      i_box_x,
    input  logic [dzfc_pkg::COORD_BITS-1:0]      i_box_y,
    input  logic [dzfc_pkg::COORD_BITS-1:0]      i_box_width,
    input  logic [dzfc_pkg::COORD_BITS-1:0]      i_box_height,
    input  logic [dzfc_pkg::SCORE_BITS-1:0]      i_class_score,
    input  logic                                 i_box_last,
    input  logic                                 i_frame_last,
    // results
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_verdict,
    output logic [dzfc_pkg::CNT_BITS-1:0]        o_person_count,
    output logic [dzfc_pkg::CNT_BITS-1:0]        o_vehicle_count,
    output logic                                 o_frame_done,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dzfc_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [dzfc_pkg::DATA_BITS-1:0]       pwdata,
    output logic [dzfc_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready
);

    localparam int LB = dzfc_pkg::LINE_BITS;
    localparam int KB = dzfc_pkg::CLASS_BITS;
    localparam int NB = dzfc_pkg::CNT_BITS;
    localparam int DB = dzfc_pkg::DIFF_BITS;
    localparam int QB = dzfc_pkg::LDIFF_BITS;
    localparam int PB = dzfc_pkg::PROD_BITS;
    localparam int HB = dzfc_pkg::HCMP_BITS;
    localparam int AB = dzfc_pkg::AREA_BITS;
    localparam int XB = dzfc_pkg::ACMP_BITS;
    localparam int RB = dzfc_pkg::AREA_REG_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dzfc_pkg::SCORE_BITS-1:0]     r_score_threshold;
    logic [LB-1:0]                       r_ignore_above_row;
    logic [4*LB:0]                       r_ignore_line;
    logic [RB-1:0]                       r_person_min_area;
    logic [4*LB-1:0]                     r_person_height_rules;
    logic [2*RB-1:0]                     r_vehicle_area_limits;
    logic [dzfc_pkg::CLASS_REG_BITS-1:0] r_person_class;
    logic [dzfc_pkg::MASK_BITS-1:0]      r_vehicle_class_mask;

    logic               cfg_wr;
    dzfc_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = dzfc_pkg::t_reg_idx'(paddr[dzfc_pkg::ADDR_BITS-1:dzfc_pkg::ADDR_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_threshold     <= dzfc_pkg::SCORE_THRESHOLD_RESET;
            r_ignore_above_row    <= '0;
            r_ignore_line         <= '0;
            r_person_min_area     <= '0;
            r_person_height_rules <= '0;
            r_vehicle_area_limits <= '0;
            r_person_class        <= '0;
            r_vehicle_class_mask  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dzfc_pkg::REG_SCORE_THRESHOLD:
                    r_score_threshold <= pwdata[dzfc_pkg::SCORE_BITS-1:0];
                dzfc_pkg::REG_IGNORE_ABOVE_ROW:    r_ignore_above_row <= pwdata[LB-1:0];
                dzfc_pkg::REG_IGNORE_LINE:         r_ignore_line <= pwdata[4*LB:0];
                dzfc_pkg::REG_PERSON_MIN_AREA:     r_person_min_area <= pwdata[RB-1:0];
                dzfc_pkg::REG_PERSON_HEIGHT_RULES: r_person_height_rules <= pwdata[4*LB-1:0];
                dzfc_pkg::REG_VEHICLE_AREA_LIMITS: r_vehicle_area_limits <= pwdata[2*RB-1:0];
                dzfc_pkg::REG_PERSON_CLASS:
                    r_person_class <= pwdata[dzfc_pkg::CLASS_REG_BITS-1:0];
                dzfc_pkg::REG_VEHICLE_CLASS_MASK:  r_vehicle_class_mask <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            dzfc_pkg::REG_SCORE_THRESHOLD:     prdata = dzfc_pkg::DATA_BITS'(r_score_threshold);
            dzfc_pkg::REG_IGNORE_ABOVE_ROW:    prdata = dzfc_pkg::DATA_BITS'(r_ignore_above_row);
            dzfc_pkg::REG_IGNORE_LINE:         prdata = dzfc_pkg::DATA_BITS'(r_ignore_line);
            dzfc_pkg::REG_PERSON_MIN_AREA:     prdata = dzfc_pkg::DATA_BITS'(r_person_min_area);
            dzfc_pkg::REG_PERSON_HEIGHT_RULES:
                prdata = dzfc_pkg::DATA_BITS'(r_person_height_rules);
            dzfc_pkg::REG_VEHICLE_AREA_LIMITS:
                prdata = dzfc_pkg::DATA_BITS'(r_vehicle_area_limits);
            dzfc_pkg::REG_PERSON_CLASS:        prdata = dzfc_pkg::DATA_BITS'(r_person_class);
            dzfc_pkg::REG_VEHICLE_CLASS_MASK:  prdata = r_vehicle_class_mask;
            default:                           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic               r_a_valid;
    dzfc_pkg::t_stage_a r_a;
    logic               r_b_valid;
    dzfc_pkg::t_stage_b r_b;
    logic               r_out_valid;

    logic out_free;
    logic b_adv;
    logic b_free;
    logic a_adv;
    logic in_acc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign b_adv      = r_b_valid && out_free;
    assign b_free     = !r_b_valid || b_adv;
    // a score without box_last retires in stage A
    assign a_adv      = r_a_valid && (!r_a.box_last || b_free);
    assign o_in_ready = !r_a_valid || a_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Stage A: input register, argmax, geometry products
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a.x          <= i_box_x;
            r_a.y          <= i_box_y;
            r_a.w          <= i_box_width;
            r_a.h          <= i_box_height;
            r_a.score      <= i_class_score;
            r_a.box_last   <= i_box_last;
            r_a.frame_last <= i_frame_last;
        end
    end

    logic [dzfc_pkg::SCORE_BITS-1:0] r_best_score;
    logic [KB-1:0]                   r_best_class;
    logic [KB-1:0]                   r_class_pos;

    logic                            take;
    logic [dzfc_pkg::SCORE_BITS-1:0] n_best_score;
    logic [KB-1:0]                   n_best_class;

    // first maximum wins; position zero always loads
    assign take         = (r_class_pos == '0) || (r_a.score > r_best_score);
    assign n_best_score = take ? r_a.score : r_best_score;
    assign n_best_class = take ? r_class_pos : r_best_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_best_score <= '0;
            r_best_class <= '0;
            r_class_pos  <= '0;
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                if (r_a.box_last) begin
                    r_best_score <= '0;
                    r_best_class <= '0;
                    r_class_pos  <= '0;
                end else begin
                    r_best_score <= n_best_score;
                    r_best_class <= n_best_class;
                    if (r_class_pos != KB'(dzfc_pkg::NUM_CLASSES - 1)) begin
                        r_class_pos <= r_class_pos + KB'(1);
                    end
                end
            end
        end
    end

    // Ignore line endpoints
    logic [LB-1:0] line_ax, line_ay, line_bx, line_by;
    assign line_ax = r_ignore_line[LB-1:0];
    assign line_ay = r_ignore_line[2*LB-1:LB];
    assign line_bx = r_ignore_line[3*LB-1:2*LB];
    assign line_by = r_ignore_line[4*LB-1:3*LB];

    logic [dzfc_pkg::BOT_BITS-1:0] a_bottom;
    logic [dzfc_pkg::BOT_BITS-1:0] a_right;
    logic signed [QB-1:0]          a_ldx, a_ldy;
    logic signed [DB-1:0]          a_cdy, a_cdx_l, a_cdx_r;

    assign a_bottom = dzfc_pkg::BOT_BITS'(r_a.y) + dzfc_pkg::BOT_BITS'(r_a.h);
    assign a_right  = dzfc_pkg::BOT_BITS'(r_a.x) + dzfc_pkg::BOT_BITS'(r_a.w);
    assign a_ldx    = $signed(QB'(line_bx)) - $signed(QB'(line_ax));
    assign a_ldy    = $signed(QB'(line_by)) - $signed(QB'(line_ay));
    assign a_cdy    = $signed(DB'(a_bottom)) - $signed(DB'(line_ay));
    assign a_cdx_l  = $signed(DB'(r_a.x)) - $signed(DB'(line_ax));
    assign a_cdx_r  = $signed(DB'(a_right)) - $signed(DB'(line_ax));

    // Stage B register: loads only for a box's last score
    always_ff @(posedge i_clk) begin
        if (a_adv && r_a.box_last) begin
            r_b.best_score <= n_best_score;
            r_b.best_class <= n_best_class;
            r_b.x          <= r_a.x;
            r_b.h          <= r_a.h;
            r_b.bottom     <= a_bottom;
            r_b.area       <= AB'(r_a.w) * AB'(r_a.h);
            r_b.p_common   <= PB'(a_ldx) * PB'(a_cdy);
            r_b.p_left     <= PB'(a_ldy) * PB'(a_cdx_l);
            r_b.p_right    <= PB'(a_ldy) * PB'(a_cdx_r);
            r_b.frame_last <= r_a.frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv && r_a.box_last) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: box tests and frame counts
    // ------------------------------------------------------------------
    logic [HB-1:0] hr_min, hr_max, hr_col, hr_smax, b_h, b_x;
    logic [XB-1:0] b_area, pa_min, va_min, va_max;
    logic [dzfc_pkg::CLASS_REG_BITS-1:0] b_class6;

    assign hr_min   = HB'(r_person_height_rules[LB-1:0]);
    assign hr_max   = HB'(r_person_height_rules[2*LB-1:LB]);
    assign hr_col   = HB'(r_person_height_rules[3*LB-1:2*LB]);
    assign hr_smax  = HB'(r_person_height_rules[4*LB-1:3*LB]);
    assign b_h      = HB'(r_b.h);
    assign b_x      = HB'(r_b.x);
    assign b_area   = XB'(r_b.area);
    assign pa_min   = XB'(r_person_min_area);
    assign va_min   = XB'(r_vehicle_area_limits[RB-1:0]);
    assign va_max   = XB'(r_vehicle_area_limits[2*RB-1:RB]);
    assign b_class6 = dzfc_pkg::CLASS_REG_BITS'(r_b.best_class);

    logic base_ok, zone_ok, line_ok, person_ok, vehicle_ok;

    assign base_ok = (r_b.best_score >= r_score_threshold) &&
                     (r_b.bottom >= dzfc_pkg::BOT_BITS'(r_ignore_above_row));
    // either bottom corner on or below the line
    assign line_ok = (r_b.p_common >= r_b.p_left) || (r_b.p_common >= r_b.p_right);
    assign zone_ok = !r_ignore_line[4*LB] || line_ok;

    assign person_ok = base_ok && zone_ok &&
                       (b_class6 == r_person_class) &&
                       (b_area >= pa_min) &&
                       (b_h >= hr_min) &&
                       ((hr_max == '0) || (b_h <= hr_max)) &&
                       ((hr_smax == '0) || (hr_col == '0) ||
                        ((b_x >= hr_col) && (b_h <= hr_smax)));

    assign vehicle_ok = base_ok && zone_ok &&
                        r_vehicle_class_mask[b_class6] &&
                        (b_area >= va_min) &&
                        ((va_max == '0) || (b_area <= va_max));

    logic [NB-1:0]      r_persons_seen, r_vehicles_seen;
    logic [NB-1:0]      n_persons_seen, n_vehicles_seen;
    dzfc_pkg::t_verdict n_verdict;

    always_comb begin
        n_persons_seen  = r_persons_seen;
        n_vehicles_seen = r_vehicles_seen;
        n_verdict       = dzfc_pkg::VERDICT_REJECT;
        if (person_ok) begin
            n_verdict = dzfc_pkg::VERDICT_PERSON;
            if (r_persons_seen < NB'(dzfc_pkg::MAX_COUNT)) begin
                n_persons_seen = r_persons_seen + NB'(1);
            end
        end else if (vehicle_ok) begin
            n_verdict = dzfc_pkg::VERDICT_VEHICLE;
            if (r_vehicles_seen < NB'(dzfc_pkg::MAX_COUNT)) begin
                n_vehicles_seen = r_vehicles_seen + NB'(1);
            end
        end
    end

    // Counts clear once the frame's last box is reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persons_seen  <= '0;
            r_vehicles_seen <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (b_adv) begin
                r_persons_seen  <= r_b.frame_last ? '0 : n_persons_seen;
                r_vehicles_seen <= r_b.frame_last ? '0 : n_vehicles_seen;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            o_verdict       <= n_verdict;
            o_person_count  <= n_persons_seen;
            o_vehicle_count <= n_vehicles_seen;
            o_frame_done    <= r_b.frame_last;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_person_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == dzfc_pkg::VERDICT_PERSON) |-> (o_person_count != '0))
        else $error("person verdict with zero person count");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && r_b.frame_last) |=> (r_persons_seen == '0 && r_vehicles_seen == '0))
        else $error("frame counts not cleared after last box");

    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_adv && r_a.box_last) |=> (r_class_pos == '0 && r_best_score == '0))
        else $error("argmax not restarted after box end");

    a_count_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_adv && !r_b.frame_last) |=>
            (r_persons_seen >= $past(r_persons_seen) &&
             r_vehicles_seen >= $past(r_vehicles_seen)))
        else $error("frame count decreased inside a frame");

endmodule

// File: bench/zone_count_scoreboard_pkg.sv
package zone_count_scoreboard_pkg;

    // One box verdict as it leaves the block
    typedef struct packed {
        dzfc_pkg::t_verdict            verdict;
        logic [dzfc_pkg::CNT_BITS-1:0] persons;
        logic [dzfc_pkg::CNT_BITS-1:0] vehicles;
        logic                          frame_done;
    } t_zone_result;

    class zone_count_scoreboard;
        // register copies
        logic [dzfc_pkg::SCORE_BITS-1:0]     score_floor;
        logic [dzfc_pkg::LINE_BITS-1:0]      row_cut;
        logic [48:0]                         line_reg;
        logic [dzfc_pkg::AREA_REG_BITS-1:0]  person_area_min;
        logic [47:0]                         height_rules;
        logic [47:0]                         vehicle_area;
        logic [dzfc_pkg::CLASS_REG_BITS-1:0] person_idx;
        logic [dzfc_pkg::MASK_BITS-1:0]      vehicle_mask;
        // argmax and per-frame tallies
        logic [dzfc_pkg::SCORE_BITS-1:0]     top_score;
        logic [dzfc_pkg::CLASS_BITS-1:0]     top_class;
        logic [dzfc_pkg::CLASS_BITS-1:0]     score_pos;
        logic [dzfc_pkg::CNT_BITS-1:0]       persons;
        logic [dzfc_pkg::CNT_BITS-1:0]       vehicles;
        t_zone_result                        due_results[$];
        int                                  mismatches;

        function void clear();
            score_floor     = dzfc_pkg::SCORE_THRESHOLD_RESET;
            row_cut         = '0;
            line_reg        = '0;
            person_area_min = '0;
            height_rules    = '0;
            vehicle_area    = '0;
            person_idx      = '0;
            vehicle_mask    = '0;
            top_score       = '0;
            top_class       = '0;
            score_pos       = '0;
            persons         = '0;
            vehicles        = '0;
            mismatches      = 0;
            due_results.delete();
        endfunction

        function void write_reg(dzfc_pkg::t_reg_idx idx,
                                logic [dzfc_pkg::DATA_BITS-1:0] value);
            case (idx)
                dzfc_pkg::REG_SCORE_THRESHOLD:
                    score_floor = value[dzfc_pkg::SCORE_BITS-1:0];
                dzfc_pkg::REG_IGNORE_ABOVE_ROW:
                    row_cut = value[dzfc_pkg::LINE_BITS-1:0];
                dzfc_pkg::REG_IGNORE_LINE:         line_reg     = value[48:0];
                dzfc_pkg::REG_PERSON_MIN_AREA:
                    person_area_min = value[dzfc_pkg::AREA_REG_BITS-1:0];
                dzfc_pkg::REG_PERSON_HEIGHT_RULES: height_rules = value[47:0];
                dzfc_pkg::REG_VEHICLE_AREA_LIMITS: vehicle_area = value[47:0];
                dzfc_pkg::REG_PERSON_CLASS:
                    person_idx = value[dzfc_pkg::CLASS_REG_BITS-1:0];
                dzfc_pkg::REG_VEHICLE_CLASS_MASK:
                    vehicle_mask = value[dzfc_pkg::MASK_BITS-1:0];
                default: ;
            endcase
        endfunction

        // corner on or below the slanted line (signed cross product)
        function bit corner_clear(longint cx, longint cy);
            longint ax, ay, bx, by;
            ax = longint'(line_reg[11:0]);
            ay = longint'(line_reg[23:12]);
            bx = longint'(line_reg[35:24]);
            by = longint'(line_reg[47:36]);
            return (bx - ax) * (cy - ay) >= (by - ay) * (cx - ax);
        endfunction

        function bit person_fits(logic [dzfc_pkg::COORD_BITS-1:0] x,
                                 logic [dzfc_pkg::COORD_BITS-1:0] h,
                                 logic [dzfc_pkg::AREA_BITS-1:0] area);
            logic [dzfc_pkg::LINE_BITS-1:0] hmin, hmax, col, smax;
            hmin = height_rules[11:0];
            hmax = height_rules[23:12];
            col  = height_rules[35:24];
            smax = height_rules[47:36];
            if (top_class != person_idx) return 1'b0;
            if (area < person_area_min) return 1'b0;
            if (h < hmin) return 1'b0;
            if (hmax != 0 && h > hmax) return 1'b0;
            if (smax != 0 && col != 0 && !(x >= col && h <= smax)) return 1'b0;
            return 1'b1;
        endfunction

        function bit vehicle_fits(logic [dzfc_pkg::AREA_BITS-1:0] area);
            logic [dzfc_pkg::AREA_REG_BITS-1:0] amin, amax;
            amin = vehicle_area[23:0];
            amax = vehicle_area[47:24];
            if (!vehicle_mask[top_class]) return 1'b0;
            if (area < amin) return 1'b0;
            if (amax != 0 && area > amax) return 1'b0;
            return 1'b1;
        endfunction

        // fold one accepted score request into the argmax, judge on box end
        function void note_request(dzfc_pkg::t_stage_a req);
            logic [dzfc_pkg::BOT_BITS-1:0]  bottom;
            logic [dzfc_pkg::AREA_BITS-1:0] area;
            bit                             zone;
            t_zone_result                   res;
            if (score_pos == 0 || req.score > top_score) begin
                top_score = req.score;
                top_class = score_pos;
            end
            if (!req.box_last) begin
                // position holds at the last class index
                if (score_pos < dzfc_pkg::NUM_CLASSES - 1) score_pos++;
                return;
            end
            bottom = dzfc_pkg::BOT_BITS'(req.y) + dzfc_pkg::BOT_BITS'(req.h);
            area   = dzfc_pkg::AREA_BITS'(req.w) * dzfc_pkg::AREA_BITS'(req.h);
            res.verdict = dzfc_pkg::VERDICT_REJECT;
            if (top_score >= score_floor && bottom >= row_cut) begin
                zone = 1'b1;
                if (line_reg[48])
                    zone = corner_clear(longint'(req.x), longint'(bottom)) ||
                           corner_clear(longint'(req.x) + longint'(req.w), longint'(bottom));
                // vehicle rules only get a try when the person rules fail
                if (zone && person_fits(req.x, req.h, area)) begin
                    res.verdict = dzfc_pkg::VERDICT_PERSON;
                    if (persons < dzfc_pkg::MAX_COUNT) persons++;
                end else if (zone && vehicle_fits(area)) begin
                    res.verdict = dzfc_pkg::VERDICT_VEHICLE;
                    if (vehicles < dzfc_pkg::MAX_COUNT) vehicles++;
                end
            end
            res.persons    = persons;
            res.vehicles   = vehicles;
            res.frame_done = req.frame_last;
            due_results = {due_results, res};
            top_score = '0;
            top_class = '0;
            score_pos = '0;
            if (req.frame_last) begin
                persons  = '0;
                vehicles = '0;
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endtask

        task check_result(t_zone_result got);
            t_zone_result want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result with none pending: verdict %0d",
                                          got.verdict));
                return;
            end
            want = due_results.pop_front();
            if (got.verdict !== want.verdict)
                report_mismatch($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
            if (got.persons !== want.persons)
                report_mismatch($sformatf("person count %0d, want %0d",
                                          got.persons, want.persons));
            if (got.vehicles !== want.vehicles)
                report_mismatch($sformatf("vehicle count %0d, want %0d",
                                          got.vehicles, want.vehicles));
            if (got.frame_done !== want.frame_done)
                report_mismatch($sformatf("frame done %0b, want %0b",
                                          got.frame_done, want.frame_done));
        endtask

        task close_out();
            if (due_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        endtask

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

endpackage

// File: bench/tb_detection_zone_filter_counter.sv
module tb_detection_zone_filter_counter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int REG_WIDTH [dzfc_pkg::NUM_REGS] = '{16, 12, 49, 24, 48, 48, 6, 64};

    typedef logic [dzfc_pkg::DATA_BITS-1:0] t_zone_regs [dzfc_pkg::NUM_REGS];

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [dzfc_pkg::COORD_BITS-1:0] i_box_x;
    logic [dzfc_pkg::COORD_BITS-1:0] i_box_y;
    logic [dzfc_pkg::COORD_BITS-1:0] i_box_width;
    logic [dzfc_pkg::COORD_BITS-1:0] i_box_height;
    logic [dzfc_pkg::SCORE_BITS-1:0] i_class_score;
    logic                            i_box_last;
    logic                            i_frame_last;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [1:0]                      o_verdict;
    logic [dzfc_pkg::CNT_BITS-1:0]   o_person_count;
    logic [dzfc_pkg::CNT_BITS-1:0]   o_vehicle_count;
    logic                            o_frame_done;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [dzfc_pkg::ADDR_BITS-1:0]  paddr;
    logic [dzfc_pkg::DATA_BITS-1:0]  pwdata;
    logic [dzfc_pkg::DATA_BITS-1:0]  prdata;
    logic                            pready;

    zone_count_scoreboard_pkg::zone_count_scoreboard tally;
    bit in_idling     = 1'b1;
    bit out_idling    = 1'b1;
    int hold_off_left = 0;
    int cycles_run    = 0;

    detection_zone_filter_counter dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("detection_zone_filter_counter regression: fail");
            $finish;
        end
    end

    // accepted score requests feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            tally.note_request(dzfc_pkg::t_stage_a'({i_box_x, i_box_y, i_box_width,
                                                     i_box_height, i_class_score,
                                                     i_box_last, i_frame_last}));
    end

    // accepted results are checked in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tally.check_result(zone_count_scoreboard_pkg::t_zone_result'({o_verdict,
                                   o_person_count, o_vehicle_count, o_frame_done}));
    end

    // result side: random stalls, plus a long hold-off on demand
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                i_out_ready <= 1'b0;
                hold_off_left--;
            end else begin
                i_out_ready <= !(out_idling && ($urandom_range(99) < 7));
            end
        end
    end

    function automatic dzfc_pkg::t_stage_a box_req(int x, int y, int w, int h, int score,
                                                   bit box_end, bit frame_end);
        dzfc_pkg::t_stage_a req;
        req.x          = dzfc_pkg::COORD_BITS'(x);
        req.y          = dzfc_pkg::COORD_BITS'(y);
        req.w          = dzfc_pkg::COORD_BITS'(w);
        req.h          = dzfc_pkg::COORD_BITS'(h);
        req.score      = dzfc_pkg::SCORE_BITS'(score);
        req.box_last   = box_end;
        req.frame_last = frame_end;
        return req;
    endfunction

    function automatic logic [dzfc_pkg::COORD_BITS-1:0] pick_coord();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 16) return '1;
        if (roll < 60) return dzfc_pkg::COORD_BITS'($urandom_range(0, 600));
        return dzfc_pkg::COORD_BITS'($urandom);
    endfunction

    function automatic logic [dzfc_pkg::SCORE_BITS-1:0] pick_score(
            logic [dzfc_pkg::SCORE_BITS-1:0] prev);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        if (roll < 35) return prev;   // ties
        return dzfc_pkg::SCORE_BITS'($urandom);
    endfunction

    function automatic dzfc_pkg::t_stage_a random_box();
        dzfc_pkg::t_stage_a req;
        req   = box_req(0, 0, 0, 0, 0, 1'b0, 1'b0);
        req.x = pick_coord();
        req.y = pick_coord();
        req.w = pick_coord();
        req.h = pick_coord();
        return req;
    endfunction

    // every register at zero or at its full-width maximum
    function automatic t_zone_regs extreme_regs(bit all_ones);
        t_zone_regs r;
        for (int i = 0; i < dzfc_pkg::NUM_REGS; i++)
            r[i] = all_ones ? ({dzfc_pkg::DATA_BITS{1'b1}} >>
                               (dzfc_pkg::DATA_BITS - REG_WIDTH[i])) : '0;
        return r;
    endfunction

    // settings that let a fair share of boxes through each rule
    function automatic t_zone_regs random_regs();
        t_zone_regs r;
        r[dzfc_pkg::REG_SCORE_THRESHOLD]  = dzfc_pkg::DATA_BITS'($urandom_range(0, 45000));
        r[dzfc_pkg::REG_IGNORE_ABOVE_ROW] = dzfc_pkg::DATA_BITS'(
            ($urandom_range(99) < 40) ? 0 : $urandom_range(0, 4095));
        r[dzfc_pkg::REG_IGNORE_LINE]      = {15'd0, 1'($urandom_range(1)), 12'($urandom),
                                             12'($urandom), 12'($urandom), 12'($urandom)};
        r[dzfc_pkg::REG_PERSON_MIN_AREA]  = dzfc_pkg::DATA_BITS'(
            ($urandom_range(99) < 40) ? 0 : $urandom_range(0, 500000));
        r[dzfc_pkg::REG_PERSON_HEIGHT_RULES] = {16'd0,
            12'(($urandom_range(99) < 30) ? 0 : $urandom_range(200, 4095)),
            12'(($urandom_range(99) < 30) ? 0 : $urandom_range(0, 4095)),
            12'(($urandom_range(99) < 50) ? 0 : $urandom_range(300, 4095)),
            12'($urandom_range(0, 300))};
        r[dzfc_pkg::REG_VEHICLE_AREA_LIMITS] = {16'd0,
            24'(($urandom_range(99) < 40) ? 0 : $urandom_range(100000, 16777215)),
            24'(($urandom_range(99) < 40) ? 0 : $urandom_range(0, 500000))};
        r[dzfc_pkg::REG_PERSON_CLASS]       = dzfc_pkg::DATA_BITS'($urandom_range(0, 5));
        r[dzfc_pkg::REG_VEHICLE_CLASS_MASK] = {$urandom, $urandom};
        return r;
    endfunction

    // offer one score request and hold it until accepted
    task automatic offer(dzfc_pkg::t_stage_a req);
        if (in_idling && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_box_x       <= req.x;
        i_box_y       <= req.y;
        i_box_width   <= req.w;
        i_box_height  <= req.h;
        i_class_score <= req.score;
        i_box_last    <= req.box_last;
        i_frame_last  <= req.frame_last;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering and wait for every pending result
    task automatic quiesce();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tally.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // setup then access; pready is sampled on the access cycle
    task automatic apb_write(dzfc_pkg::t_reg_idx idx,
                             logic [dzfc_pkg::DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dzfc_pkg::ADDR_BITS'(idx) << dzfc_pkg::ADDR_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tally.write_reg(idx, value);
    endtask

    task automatic program_zone(t_zone_regs regs);
        for (int i = 0; i < dzfc_pkg::NUM_REGS; i++)
            apb_write(dzfc_pkg::t_reg_idx'(i), regs[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // box whose scores peak at class index peak
    task automatic scored_box(dzfc_pkg::t_stage_a geom, int peak, bit frame_end);
        dzfc_pkg::t_stage_a req;
        req = geom;
        for (int k = 0; k <= peak; k++) begin
            req.score      = (k == peak) ? dzfc_pkg::SCORE_BITS'(60000)
                                         : dzfc_pkg::SCORE_BITS'(1000 + k);
            req.box_last   = (k == peak);
            req.frame_last = frame_end && (k == peak);
            offer(req);
        end
    endtask

    // random frames of random boxes; frame_last noise on inner scores
    task automatic run_frames(int item_budget, bit long_boxes);
        dzfc_pkg::t_stage_a              geom, req;
        int                              boxes, n_scores, sent;
        logic [dzfc_pkg::SCORE_BITS-1:0] prev;
        sent = 0;
        prev = '0;
        while (sent < item_budget) begin
            boxes = $urandom_range(1, 10);
            for (int b = 0; b < boxes; b++) begin
                geom = random_box();
                if (long_boxes && $urandom_range(99) < 2) n_scores = $urandom_range(60, 70);
                else n_scores = $urandom_range(1, 6);
                for (int k = 0; k < n_scores; k++) begin
                    req = ($urandom_range(99) < 20) ? random_box() : geom;
                    req.score = pick_score(prev);
                    prev = req.score;
                    req.box_last = (k == n_scores - 1);
                    req.frame_last = req.box_last ? (b == boxes - 1) : ($urandom_range(99) < 10);
                    offer(req);
                    sent++;
                end
            end
        end
    endtask

    // one long frame of single-score boxes to push a count into saturation
    task automatic flood_frame(int boxes);
        dzfc_pkg::t_stage_a req;
        for (int b = 0; b < boxes; b++) begin
            req = random_box();
            req.score = dzfc_pkg::SCORE_BITS'($urandom);
            req.box_last = 1'b1;
            req.frame_last = (b == boxes - 1);
            offer(req);
        end
    endtask

    initial begin
        t_zone_regs regs;
        tally = new();
        tally.clear();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_box_x       = '0;
        i_box_y       = '0;
        i_box_width   = '0;
        i_box_height  = '0;
        i_class_score = '0;
        i_box_last    = 1'b0;
        i_frame_last  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: threshold edges, extreme geometry, ties, late winner
        offer(box_req(0, 0, 0, 0, 65535, 1, 0));
        offer(box_req(4095, 4095, 4095, 4095, 19660, 1, 0));
        offer(box_req(4095, 4095, 4095, 4095, 19661, 1, 0));
        offer(box_req(10, 10, 10, 10, 30000, 0, 0));
        offer(box_req(10, 10, 10, 10, 30000, 1, 0));
        offer(box_req(20, 20, 20, 20, 100, 0, 1));
        offer(box_req(20, 20, 20, 20, 40000, 1, 1));
        quiesce();

        // slanted line, row cut, special column, vehicle area window
        regs = extreme_regs(1'b0);
        regs[dzfc_pkg::REG_IGNORE_ABOVE_ROW]    = 64'd500;
        regs[dzfc_pkg::REG_IGNORE_LINE]         = {15'd0, 1'b1, 12'd0, 12'd4000,
                                                   12'd2000, 12'd0};
        regs[dzfc_pkg::REG_PERSON_MIN_AREA]     = 64'd100;
        regs[dzfc_pkg::REG_PERSON_HEIGHT_RULES] = {16'd0, 12'd300, 12'd1000,
                                                   12'd2000, 12'd20};
        regs[dzfc_pkg::REG_VEHICLE_AREA_LIMITS] = {16'd0, 24'd50000, 24'd1000};
        regs[dzfc_pkg::REG_PERSON_CLASS]        = 64'd2;
        regs[dzfc_pkg::REG_VEHICLE_CLASS_MASK]  = 64'h8000_0000_0000_0008;
        program_zone(regs);
        scored_box(box_req(1200, 1900, 50, 250, 0, 0, 0), 2, 1'b0);
        scored_box(box_req(500, 1900, 50, 250, 0, 0, 0), 2, 1'b0);
        scored_box(box_req(2000, 1500, 40, 100, 0, 0, 0), 3, 1'b0);
        scored_box(box_req(2000, 1500, 400, 400, 0, 0, 0), 3, 1'b0);
        scored_box(box_req(1200, 100, 50, 100, 0, 0, 0), 2, 1'b1);
        quiesce();

        // all registers zero
        program_zone(extreme_regs(1'b0));
        run_frames(100, 1'b1);
        quiesce();

        // random settings; one phase without idling, one with a long hold-off
        for (int p = 0; p < 5; p++) begin
            program_zone(random_regs());
            in_idling  = (p != 1);
            out_idling = (p != 1);
            if (p == 2) hold_off_left = HOLD_OFF_CYCLES;
            run_frames(110, 1'b1);
            quiesce();
        end
        in_idling  = 1'b1;
        out_idling = 1'b1;

        // all registers at maximum
        program_zone(extreme_regs(1'b1));
        run_frames(60, 1'b0);
        quiesce();

        // person count saturation
        program_zone(extreme_regs(1'b0));
        flood_frame(270);
        quiesce();

        // vehicle count saturation
        regs = extreme_regs(1'b0);
        regs[dzfc_pkg::REG_PERSON_CLASS]       = 64'd1;
        regs[dzfc_pkg::REG_VEHICLE_CLASS_MASK] = 64'd1;
        program_zone(regs);
        flood_frame(270);
        quiesce();

        repeat (8) @(posedge i_clk);
        tally.close_out();
        if (tally.mismatches == 0)
            $display("detection_zone_filter_counter regression: pass");
        else
            $display("detection_zone_filter_counter regression: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/dzfc_pkg.sv
hdl/detection_zone_filter_counter.sv
bench/zone_count_scoreboard_pkg.sv
bench/tb_detection_zone_filter_counter.sv
